FILE: sv/assert_macros.svh
// Assertion macros shared by the page table walker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PFTW_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pftw assertion failed");

// Next-cycle implication, checked outside reset.
`define PFTW_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pftw assertion failed");

`endif

FILE: sv/pftw_pkg.sv
// Shared types and constants of the page table walker.
package pftw_pkg;

  localparam int VPN_W      = 20;
  localparam int FRAME_W    = 20;
  localparam int REG_W      = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int ADDR_W     = 32;
  localparam int PAGE_SHIFT = 12;

  localparam logic [1:0] KIND_RO = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FAULT = 2'd1;
  localparam logic [1:0] STATUS_NOMEM = 2'd2;

  // dirty and valid flags of the TLB lo word
  localparam logic [PAGE_SHIFT-1:0] LO_FLAGS = 12'h600;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_CHECK,
    ST_CLEAR,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_FAULT,
    RES_NOMEM,
    RES_HIT,
    RES_NEW
  } res_sel_t;

  typedef struct packed {
    logic     capture;
    logic     look;
    logic     init_wr;
    logic     clr_wr;
    logic     leaf_wr;
    res_sel_t res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic early_fault;
    logic hit;
    logic region_hit;
    logic avail;
    logic present;
    logic init_last;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/pftw_in_if.sv
// Fault item channel.
interface pftw_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       fault_kind;
  logic [pftw_pkg::ADDR_W-1:0]      fault_address;
  logic [pftw_pkg::FRAME_W-1:0]     free_frame;
  logic                             frame_available;

  modport source (output valid, fault_kind, fault_address, free_frame, frame_available,
                  input ready);
  modport sink   (input valid, fault_kind, fault_address, free_frame, frame_available,
                  output ready);
endinterface

FILE: sv/pftw_out_if.sv
// Result item channel.
interface pftw_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [pftw_pkg::ADDR_W-1:0] entry_hi;
  logic [pftw_pkg::ADDR_W-1:0] entry_lo;
  logic                        frame_taken;

  modport source (output valid, status, entry_hi, entry_lo, frame_taken, input ready);
  modport sink   (input valid, status, entry_hi, entry_lo, frame_taken, output ready);
endinterface

FILE: sv/pftw_ctrl.sv
// Walk sequencer of the page table walker.
`include "assert_macros.svh"

module pftw_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pftw_pkg::sts_t sts,
  output pftw_pkg::cmd_t cmd
);

  pftw_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pftw_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pftw_pkg::ST_INIT: begin
        if (sts.init_last) state_nxt = pftw_pkg::ST_IDLE;
      end
      pftw_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = pftw_pkg::ST_LOOK;
      end
      pftw_pkg::ST_LOOK: state_nxt = pftw_pkg::ST_CHECK;
      pftw_pkg::ST_CHECK: begin
        priority if (sts.early_fault) state_nxt = pftw_pkg::ST_DONE;
        else if (sts.hit)             state_nxt = pftw_pkg::ST_DONE;
        else if (!sts.region_hit)     state_nxt = pftw_pkg::ST_DONE;
        else if (!sts.avail)          state_nxt = pftw_pkg::ST_DONE;
        else if (!sts.present)        state_nxt = pftw_pkg::ST_CLEAR;
        else                          state_nxt = pftw_pkg::ST_WRITE;
      end
      pftw_pkg::ST_CLEAR: begin
        if (sts.clr_last) state_nxt = pftw_pkg::ST_WRITE;
      end
      pftw_pkg::ST_WRITE: state_nxt = pftw_pkg::ST_DONE;
      pftw_pkg::ST_DONE: begin
        if (sts.out_free) state_nxt = pftw_pkg::ST_IDLE;
      end
      default: state_nxt = pftw_pkg::ST_INIT;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.res_sel = pftw_pkg::RES_NONE;
    in_ready = 1'b0;
    unique case (state_r)
      pftw_pkg::ST_INIT: cmd.init_wr = 1'b1;
      pftw_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      pftw_pkg::ST_LOOK: cmd.look = 1'b1;
      pftw_pkg::ST_CHECK: begin
        priority if (sts.early_fault) cmd.res_sel = pftw_pkg::RES_FAULT;
        else if (sts.hit)             cmd.res_sel = pftw_pkg::RES_HIT;
        else if (!sts.region_hit)     cmd.res_sel = pftw_pkg::RES_FAULT;
        else if (!sts.avail)          cmd.res_sel = pftw_pkg::RES_NOMEM;
        else                          cmd.res_sel = pftw_pkg::RES_NONE;
      end
      pftw_pkg::ST_CLEAR: cmd.clr_wr = 1'b1;
      pftw_pkg::ST_WRITE: begin
        cmd.leaf_wr = 1'b1;
        cmd.res_sel = pftw_pkg::RES_NEW;
      end
      pftw_pkg::ST_DONE: cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

  // a table is only cleared for a directory slot that was absent
  `PFTW_ASSERT_IMP(a_clear_absent_dir, state_r == pftw_pkg::ST_CLEAR, !sts.present)
  // the last clearing write hands over to the leaf write
  `PFTW_ASSERT_NXT(a_clear_then_write,
                   state_r == pftw_pkg::ST_CLEAR && sts.clr_last,
                   state_r == pftw_pkg::ST_WRITE)
  // no item taken during the directory sweep after reset
  `PFTW_ASSERT_IMP(a_no_take_in_init, state_r == pftw_pkg::ST_INIT, !in_ready)

endmodule

FILE: sv/pftw_dp.sv
// Datapath of the page table walker: item registers, tables, region check, result.
`include "assert_macros.svh"

module pftw_dp #(
  parameter int DIR_BITS  = 11,
  parameter int LEAF_BITS = 9,
  parameter int REGIONS   = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [1:0]                          in_fault_kind,
  input  logic [pftw_pkg::ADDR_W-1:0]         in_fault_address,
  input  logic [pftw_pkg::FRAME_W-1:0]        in_free_frame,
  input  logic                                in_frame_available,
  input  logic                                cfg_we,
  input  logic [pftw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pftw_pkg::REG_W-1:0]          cfg_data,
  input  pftw_pkg::cmd_t                      cmd,
  output pftw_pkg::sts_t                      sts,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [pftw_pkg::ADDR_W-1:0]         out_entry_hi,
  output logic [pftw_pkg::ADDR_W-1:0]         out_entry_lo,
  output logic                                out_frame_taken
);

  localparam int SLOT_W    = DIR_BITS + LEAF_BITS;
  localparam int VPN_EXT_W = (SLOT_W > pftw_pkg::VPN_W) ? SLOT_W : pftw_pkg::VPN_W;
  localparam int DIR_DEPTH = 1 << DIR_BITS;
  localparam int MEM_DEPTH = 1 << SLOT_W;

  // item registers
  logic [1:0]                   kind_r;
  logic [pftw_pkg::ADDR_W-1:0]  addr_r;
  logic [pftw_pkg::FRAME_W-1:0] offered_r;
  logic                         avail_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r    <= in_fault_kind;
      addr_r    <= in_fault_address;
      offered_r <= in_free_frame;
      avail_r   <= in_frame_available;
    end
  end

  logic [pftw_pkg::VPN_W-1:0] vpn;
  logic [VPN_EXT_W-1:0]       vpn_ext;
  logic [DIR_BITS-1:0]        dir_idx;
  logic [LEAF_BITS-1:0]       leaf_idx;

  assign vpn      = addr_r[pftw_pkg::ADDR_W-1:pftw_pkg::PAGE_SHIFT];
  assign vpn_ext  = VPN_EXT_W'(vpn);
  assign dir_idx  = vpn_ext[LEAF_BITS +: DIR_BITS];
  assign leaf_idx = vpn_ext[LEAF_BITS-1:0];

  // region registers
  logic [pftw_pkg::REG_W-1:0] base_r  [REGIONS];
  logic [pftw_pkg::REG_W-1:0] pages_r [REGIONS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < REGIONS; r++) begin
        base_r[r]  <= '0;
        pages_r[r] <= '0;
      end
    end else if (cfg_we) begin
      for (int r = 0; r < REGIONS; r++) begin
        if (cfg_index == pftw_pkg::CFG_IDX_W'(2 * r))     base_r[r]  <= cfg_data;
        if (cfg_index == pftw_pkg::CFG_IDX_W'(2 * r + 1)) pages_r[r] <= cfg_data;
      end
    end
  end

  // region check, one add and two compares per region, no wrap on the top
  logic                       region_any;
  logic [pftw_pkg::REG_W:0]   region_top [REGIONS];
  logic                       region_hit_r;

  always_comb begin
    region_any = 1'b0;
    for (int r = 0; r < REGIONS; r++) begin
      region_top[r] = {1'b0, base_r[r]} + {1'b0, pages_r[r]};
      if (vpn >= base_r[r] && {1'b0, vpn} < region_top[r]) region_any = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look) region_hit_r <= region_any;
  end

  // sweep counters
  logic [DIR_BITS-1:0]  init_cnt_r;
  logic [LEAF_BITS-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_cnt_r <= '0;
      clr_cnt_r  <= '0;
    end else begin
      if (cmd.init_wr) init_cnt_r <= init_cnt_r + 1'b1;
      if (cmd.clr_wr)  clr_cnt_r  <= clr_cnt_r + 1'b1;
    end
  end

  // directory presence memory
  logic dir_mem [DIR_DEPTH];
  logic dir_q_r;
  logic dir_last_clr;

  assign dir_last_clr = cmd.clr_wr && (&clr_cnt_r);

  always_ff @(posedge clk) begin
    if (cmd.init_wr) begin
      dir_mem[init_cnt_r] <= 1'b0;
    end else if (dir_last_clr) begin
      dir_mem[dir_idx] <= 1'b1;
    end
    if (cmd.look) dir_q_r <= dir_mem[dir_idx];
  end

  // leaf frame memory
  logic [pftw_pkg::FRAME_W-1:0] leaf_mem [MEM_DEPTH];
  logic [pftw_pkg::FRAME_W-1:0] leaf_q_r;

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      leaf_mem[{dir_idx, clr_cnt_r}] <= '0;
    end else if (cmd.leaf_wr) begin
      leaf_mem[{dir_idx, leaf_idx}] <= offered_r;
    end
    if (cmd.look) leaf_q_r <= leaf_mem[{dir_idx, leaf_idx}];
  end

  // status to the sequencer
  assign sts.early_fault = (kind_r == pftw_pkg::KIND_RO) || (addr_r == '0);
  assign sts.hit         = dir_q_r && (leaf_q_r != '0);
  assign sts.region_hit  = region_hit_r;
  assign sts.avail       = avail_r;
  assign sts.present     = dir_q_r;
  assign sts.init_last   = &init_cnt_r;
  assign sts.clr_last    = &clr_cnt_r;
  assign sts.out_free    = !out_valid || out_ready;

  // pending result
  logic [1:0]                   res_status_r;
  logic [pftw_pkg::FRAME_W-1:0] res_frame_r;
  logic                         res_taken_r;

  always_ff @(posedge clk) begin
    unique case (cmd.res_sel)
      pftw_pkg::RES_FAULT: begin
        res_status_r <= pftw_pkg::STATUS_FAULT;
        res_taken_r  <= 1'b0;
      end
      pftw_pkg::RES_NOMEM: begin
        res_status_r <= pftw_pkg::STATUS_NOMEM;
        res_taken_r  <= 1'b0;
      end
      pftw_pkg::RES_HIT: begin
        res_status_r <= pftw_pkg::STATUS_OK;
        res_frame_r  <= leaf_q_r;
        res_taken_r  <= 1'b0;
      end
      pftw_pkg::RES_NEW: begin
        res_status_r <= pftw_pkg::STATUS_OK;
        res_frame_r  <= offered_r;
        res_taken_r  <= 1'b1;
      end
      default: ;
    endcase
  end

  // output register
  logic res_ok;
  assign res_ok = (res_status_r == pftw_pkg::STATUS_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status      <= res_status_r;
      out_frame_taken <= res_taken_r;
      out_entry_hi    <= res_ok ? {vpn, pftw_pkg::PAGE_SHIFT'(0)} : '0;
      out_entry_lo    <= res_ok ? {res_frame_r, pftw_pkg::LO_FLAGS} : '0;
    end
  end

  // the output register is only reloaded once the held item has gone
  `PFTW_ASSERT_IMP(a_load_when_free, cmd.out_load, !out_valid || out_ready)
  // a frame is only stored once the item passed the region and allocator checks
  `PFTW_ASSERT_IMP(a_store_checked, cmd.leaf_wr,
                   region_hit_r && avail_r && !sts.early_fault && !sts.hit)

endmodule

FILE: sv/page_fault_table_walker.sv
// Top level of the page table walker.
//
// Resolves one page fault item at a time through a two-level page table and
// returns one result item per fault. A mapped page goes through capture,
// table read, decision and result load into the output register; a fault
// that needs a new frame in an existing leaf table adds a leaf write; one
// that creates a leaf table also adds clearing writes to all 2^LEAF_BITS
// (512) entries, one entry per cycle through the single leaf memory write
// port. After reset the directory memory is swept clear, one entry a cycle,
// over all 2^DIR_BITS (2048) entries; no item is accepted during that sweep,
// while configuration writes are taken at any time. A new item is accepted
// as soon as the previous one sits in the output register, even if it is
// still waiting to be taken. Region registers are written through cfg_*,
// index 2r for the base page and 2r+1 for the page count of region r.
`include "assert_macros.svh"

module page_fault_table_walker #(
  parameter int DIR_BITS  = 11,
  parameter int LEAF_BITS = 9,
  parameter int REGIONS   = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  pftw_in_if.sink                          in_item,
  pftw_out_if.source                       out_item,
  input  logic                             cfg_we,
  input  logic [pftw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pftw_pkg::REG_W-1:0]       cfg_data
);

  pftw_pkg::cmd_t cmd;
  pftw_pkg::sts_t sts;
  logic           in_ready;

  assign in_item.ready = in_ready;

  // sequencer
  pftw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // tables, region check and result registers
  pftw_dp #(
    .DIR_BITS  (DIR_BITS),
    .LEAF_BITS (LEAF_BITS),
    .REGIONS   (REGIONS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_fault_kind      (in_item.fault_kind),
    .in_fault_address   (in_item.fault_address),
    .in_free_frame      (in_item.free_frame),
    .in_frame_available (in_item.frame_available),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .cmd                (cmd),
    .sts                (sts),
    .out_ready          (out_item.ready),
    .out_valid          (out_item.valid),
    .out_status         (out_item.status),
    .out_entry_hi       (out_item.entry_hi),
    .out_entry_lo       (out_item.entry_lo),
    .out_frame_taken    (out_item.frame_taken)
  );

  // every accepted item starts a table read on the next cycle
  `PFTW_ASSERT_NXT(a_accept_then_look, in_item.valid && in_ready, cmd.look)

endmodule
